>>> src/imutcf_pkg.sv
package imutcf_pkg;

  // Sequencer states of the shared arithmetic unit.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GX,
    ST_GY,
    ST_GZ,
    ST_AX,
    ST_AY,
    ST_AZ,
    ST_PX,
    ST_PY,
    ST_REW,
    ST_MSQRT,
    ST_MAG,
    ST_DCHK,
    ST_DIV,
    ST_QFIX,
    ST_PM1,
    ST_PA1,
    ST_PM2,
    ST_PA2,
    ST_PM3,
    ST_PA3,
    ST_ASQRT,
    ST_SM,
    ST_SRES,
    ST_BL1,
    ST_BL2,
    ST_BL3,
    ST_DONE
  } state_e;

  // Configuration register indexes.
  localparam logic [7:0] REG_GYRO_GAIN     = 8'd0;
  localparam logic [7:0] REG_BLEND_WEIGHT  = 8'd1;
  localparam logic [7:0] REG_GROUND_HEIGHT = 8'd2;
  localparam logic [7:0] REG_LIFT_HEIGHT   = 8'd3;

  // Fixed-point constants, Q16.16.
  localparam logic signed [32:0] FIRST_MAG   = -33'sd642646;
  localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;
  localparam logic signed [31:0] ASIN_C0     = 32'sd102939;
  localparam logic signed [31:0] ASIN_C1     = -32'sd13901;
  localparam logic signed [31:0] ASIN_C2     = 32'sd4867;
  localparam logic signed [31:0] ASIN_C3     = -32'sd1227;
  localparam logic [16:0]        ONE_Q16     = 17'd65536;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/imu_tilt_complementary_filter_unit.sv
// Tilt estimator for an inertial unit: a complementary filter.
// Input stream (s_axis_*): one transfer carries gyro, accelerometer and
// position samples. Output stream (m_axis_*): one transfer per input with
// pitch, roll, yaw, the latched ground and lift flags and the reward.
// Configuration (cfg_*): index and data, always ready; index 0 gyro gain,
// 1 blend weight, 2 ground height, 3 lift height; other indexes are ignored.
// Write it only while no sample is in flight.
// Each sample passes through one shared multiplier and one shift-subtract
// unit that does the 32-step magnitude square root, then per axis a 17-step
// divide (skipped when the axis is at least twice the magnitude), a 17-step
// square root and the arcsine polynomial, all skipped for a zero magnitude.
// No new sample is taken while one is being worked on.
// The result sits in an output register; the next sample is accepted while
// it waits, but the block holds its final step until the receiver has taken
// the previous result.
// Reset clears the angles and flags, marks the next sample as the first and
// loads the default configuration.
module imu_tilt_complementary_filter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, pos_x, pos_y, pos_z
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pitch_est, roll_est, yaw_est, touched_ground, left_ground, reward, zero pad
  output logic [167:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import imutcf_pkg::*;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0]        gain_q;
  logic [16:0]        weight_q;
  logic signed [31:0] ground_h_q, lift_h_q;

  // Filter state.
  logic signed [31:0] pitch_q, pitch_d, roll_q, roll_d, yaw_q, yaw_d;
  logic               gflag_q, gflag_d, lflag_q, lflag_d, first_q, first_d;

  // Latched sample.
  logic signed [31:0] gx_q, gy_q, gz_q, ax_q, ay_q, az_q, px_q, py_q;

  // Working registers.
  logic signed [63:0] prod_q, prod_d;
  logic [63:0]        sq_q, sq_d;
  logic signed [63:0] rew_q, rew_d;
  logic [63:0]        sv_q, sv_d, sr_q, sr_d;
  logic [4:0]         k_q, k_d;
  logic signed [32:0] mag_q, mag_d;
  logic               sel_q, sel_d, neg_q, neg_d;
  logic [47:0]        rem_q, rem_d;
  logic [31:0]        dm_q, dm_d;
  logic [16:0]        quo_q, quo_d, a_q, a_d;
  logic signed [31:0] p_q, p_d, tilt_q, tilt_d;
  logic signed [63:0] bl_q, bl_d;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic [167:0]       odata_q, odata_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               in_xfer, out_xfer;
  logic [63:0]        sq_bit, sq_try;
  logic [47:0]        dv_sub;
  logic signed [31:0] axis_v;
  logic [31:0]        axis_abs;
  logic [16:0]        w_eff;
  logic signed [63:0] gain_step, bl_sum;
  logic signed [31:0] asin_r;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign cfg_ready_o   = 1'b1;

  // Shared multiplier; its product is registered every cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GX:  begin mul_a = 33'(gx_q); mul_b = $signed({17'd0, gain_q}); end
      ST_GY:  begin mul_a = 33'(gy_q); mul_b = $signed({17'd0, gain_q}); end
      ST_GZ:  begin mul_a = 33'(gz_q); mul_b = $signed({17'd0, gain_q}); end
      ST_AX:  begin mul_a = 33'(ax_q); mul_b = 33'(ax_q); end
      ST_AY:  begin mul_a = 33'(ay_q); mul_b = 33'(ay_q); end
      ST_AZ:  begin mul_a = 33'(az_q); mul_b = 33'(az_q); end
      ST_PX:  begin mul_a = 33'(px_q); mul_b = 33'(px_q); end
      ST_PY:  begin mul_a = 33'(py_q); mul_b = 33'(py_q); end
      ST_PM1, ST_PM2, ST_PM3: begin
        mul_a = 33'(p_q);
        mul_b = $signed({16'd0, a_q});
      end
      ST_SM:  begin mul_a = $signed({1'b0, sr_q[31:0]}); mul_b = 33'(p_q); end
      ST_BL1: begin
        mul_a = sel_q ? 33'(pitch_q) : 33'(roll_q);
        mul_b = $signed({16'd0, w_eff});
      end
      ST_BL2: begin
        mul_a = 33'(tilt_q);
        mul_b = $signed({16'd0, ONE_Q16 - w_eff});
      end
      default: ;
    endcase
  end
  assign mul_p  = mul_a * mul_b;
  assign prod_d = mul_p[63:0];

  // Shared shift-subtract helpers: square root step and divide step.
  assign sq_bit   = 64'd1 << {k_q, 1'b0};
  assign sq_try   = sr_q + sq_bit;
  assign dv_sub   = {16'd0, dm_q} << k_q;
  assign axis_v   = sel_q ? ay_q : ax_q;
  assign axis_abs = axis_v[31] ? 32'(-33'(axis_v)) : 32'(axis_v);
  assign w_eff    = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;
  assign gain_step = prod_q >>> 16;
  assign bl_sum   = bl_q + prod_q;
  assign asin_r   = HALF_PI_Q16 - 32'(prod_q >>> 16);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_GX;
      ST_GX:    state_d = ST_GY;
      ST_GY:    state_d = ST_GZ;
      ST_GZ:    state_d = ST_AX;
      ST_AX:    state_d = ST_AY;
      ST_AY:    state_d = ST_AZ;
      ST_AZ:    state_d = ST_PX;
      ST_PX:    state_d = ST_PY;
      ST_PY:    state_d = ST_REW;
      ST_REW:   state_d = ST_MSQRT;
      ST_MSQRT: if (k_q == 5'd0) state_d = ST_MAG;
      ST_MAG:   state_d = ST_DCHK;
      ST_DCHK: begin
        if (mag_q == '0) begin
          state_d = ST_BL1;
        end else if ({1'b0, axis_abs[31:1]} >= (mag_q[32] ? 32'(-mag_q) : 32'(mag_q))) begin
          state_d = ST_PM1;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:   if (k_q == 5'd0) state_d = ST_QFIX;
      ST_QFIX:  state_d = ST_PM1;
      ST_PM1:   state_d = ST_PA1;
      ST_PA1:   state_d = ST_PM2;
      ST_PM2:   state_d = ST_PA2;
      ST_PA2:   state_d = ST_PM3;
      ST_PM3:   state_d = ST_PA3;
      ST_PA3:   state_d = ST_ASQRT;
      ST_ASQRT: if (k_q == 5'd0) state_d = ST_SM;
      ST_SM:    state_d = ST_SRES;
      ST_SRES:  state_d = ST_BL1;
      ST_BL1:   state_d = ST_BL2;
      ST_BL2:   state_d = ST_BL3;
      ST_BL3:   state_d = sel_q ? ST_DONE : ST_DCHK;
      ST_DONE:  if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath updates driven by the sequencer.
  always_comb begin
    pitch_d = pitch_q;  roll_d = roll_q;  yaw_d = yaw_q;
    gflag_d = gflag_q;  lflag_d = lflag_q; first_d = first_q;
    sq_d = sq_q;  rew_d = rew_q;  sv_d = sv_q;  sr_d = sr_q;  k_d = k_q;
    mag_d = mag_q;  sel_d = sel_q;  neg_d = neg_q;  rem_d = rem_q;  dm_d = dm_q;
    quo_d = quo_q;  a_d = a_q;  p_d = p_q;  tilt_d = tilt_q;  bl_d = bl_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    case (state_q)
      ST_IDLE: begin
        // Height flags latch as the sample comes in.
        if (in_xfer) begin
          if ($signed(s_axis_tdata[287:256]) < ground_h_q) gflag_d = 1'b1;
          if ($signed(s_axis_tdata[287:256]) > lift_h_q)   lflag_d = 1'b1;
        end
      end
      ST_GY: roll_d  = sat32(64'(roll_q) + gain_step);
      ST_GZ: pitch_d = sat32(64'(pitch_q) + gain_step);
      ST_AX: yaw_d   = sat32(64'(yaw_q) + gain_step);
      ST_AY: sq_d = prod_q;
      ST_AZ: sq_d = sq_q + prod_q;
      ST_PX: sq_d = sq_q + prod_q;
      ST_PY: rew_d = prod_q;
      ST_REW: begin
        rew_d = rew_q - prod_q;
        sv_d  = sq_q;
        sr_d  = '0;
        k_d   = 5'd31;
      end
      ST_MSQRT, ST_ASQRT: begin
        // One digit of the square root per cycle.
        if (sv_q >= sq_try) begin
          sv_d = sv_q - sq_try;
          sr_d = (sr_q >> 1) + sq_bit;
        end else begin
          sr_d = sr_q >> 1;
        end
        k_d = k_q - 5'd1;
      end
      ST_MAG: begin
        mag_d   = first_q ? FIRST_MAG : $signed({1'b0, sr_q[31:0]});
        first_d = 1'b0;
        sel_d   = 1'b0;
      end
      ST_DCHK: begin
        tilt_d = '0;
        neg_d  = axis_v[31] ^ mag_q[32];
        rem_d  = {axis_abs, 16'd0};
        dm_d   = mag_q[32] ? 32'(-mag_q) : 32'(mag_q);
        quo_d  = '0;
        k_d    = 5'd16;
        a_d    = ONE_Q16;
        p_d    = ASIN_C3;
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if (rem_q >= dv_sub) begin
          rem_d = rem_q - dv_sub;
          quo_d = quo_q | (17'd1 << k_q);
        end
        k_d = k_q - 5'd1;
      end
      ST_QFIX: begin
        a_d   = (quo_q > ONE_Q16) ? ONE_Q16 : quo_q;
        neg_d = neg_q && (quo_q != '0);
      end
      ST_PA1: p_d = 32'(prod_q >>> 16) + ASIN_C2;
      ST_PA2: p_d = 32'(prod_q >>> 16) + ASIN_C1;
      ST_PA3: begin
        p_d  = 32'(prod_q >>> 16) + ASIN_C0;
        sv_d = {31'd0, 17'(ONE_Q16 - a_q), 16'd0};
        sr_d = '0;
        k_d  = 5'd16;
      end
      ST_SRES: tilt_d = neg_q ? -asin_r : asin_r;
      ST_BL2:  bl_d = prod_q;
      ST_BL3: begin
        if (sel_q) pitch_d = sat32(bl_sum >>> 16);
        else       roll_d  = sat32(bl_sum >>> 16);
        sel_d = 1'b1;
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {6'd0, ((gflag_q || lflag_q) ? 64'd0 : 64'(rew_q)),
                      lflag_q, gflag_q, yaw_q, roll_q, pitch_q};
        end
      end
      default: ;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gain_q     <= 16'd1872;
      weight_q   <= 17'd65484;
      ground_h_q <= 32'sd4915;
      lift_h_q   <= 32'sd19661;
      pitch_q    <= '0;
      roll_q     <= '0;
      yaw_q      <= '0;
      gflag_q    <= 1'b0;
      lflag_q    <= 1'b0;
      first_q    <= 1'b1;
      ovalid_q   <= 1'b0;
      k_q        <= '0;
      sel_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      pitch_q  <= pitch_d;
      roll_q   <= roll_d;
      yaw_q    <= yaw_d;
      gflag_q  <= gflag_d;
      lflag_q  <= lflag_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      sel_q    <= sel_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GYRO_GAIN:     gain_q     <= cfg_data_i[15:0];
          REG_BLEND_WEIGHT:  weight_q   <= cfg_data_i[16:0];
          REG_GROUND_HEIGHT: ground_h_q <= cfg_data_i;
          REG_LIFT_HEIGHT:   lift_h_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      gx_q <= s_axis_tdata[31:0];
      gy_q <= s_axis_tdata[63:32];
      gz_q <= s_axis_tdata[95:64];
      ax_q <= s_axis_tdata[127:96];
      ay_q <= s_axis_tdata[159:128];
      az_q <= s_axis_tdata[191:160];
      px_q <= s_axis_tdata[223:192];
      py_q <= s_axis_tdata[255:224];
    end
    prod_q  <= prod_d;
    sq_q    <= sq_d;
    rew_q   <= rew_d;
    sv_q    <= sv_d;
    sr_q    <= sr_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    dm_q    <= dm_d;
    quo_q   <= quo_d;
    a_q     <= a_d;
    p_q     <= p_d;
    tilt_q  <= tilt_d;
    bl_q    <= bl_d;
    odata_q <= odata_d;
  end

`ifndef NO_ASSERTIONS
  // Once a result has been delivered the first-sample quirk is spent.
  a_first_spent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |=> !first_q) else $error("first-sample flag still set after a result");

  // A result with a latched flag carries no reward.
  a_reward_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[96] || m_axis_tdata[97])) |-> m_axis_tdata[161:98] == '0)
    else $error("reward not forced to zero");

  // The arcsine argument never exceeds one.
  a_asin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PM1) |-> a_q <= ONE_Q16) else $error("arcsine argument out of range");

  // The divider never runs beyond the top quotient bit.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> k_q <= 5'd16) else $error("divide step counter out of range");
`endif

endmodule

>>> tb/tb_imu_tilt_complementary_filter_unit.sv
module tb_imu_tilt_complementary_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imutcf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint Q_ONE = 64'sd65536;
  localparam logic signed [31:0] IN_BAND = 32'sd8192;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] G_Q16 = 32'sd642646;
  localparam logic [7:0] REG_UNUSED = 8'd9;

  // One input sample, first field in the lowest bits.
  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] accel_z;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_x;
    logic signed [31:0] gyro_z;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_x;
  } sample_t;

  // One estimate, first field in the lowest bits.
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [63:0] reward;
    logic               left_ground;
    logic               touched_ground;
    logic signed [31:0] yaw_est;
    logic signed [31:0] roll_est;
    logic signed [31:0] pitch_est;
  } estimate_t;

  typedef struct {
    sample_t   smp;
    bit        fixed;
    estimate_t est;
  } vector_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  imu_tilt_complementary_filter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter state and registers as the block should hold them.
  logic [15:0]        gain_q = 16'd1872;
  logic [16:0]        weight_q = 17'd65484;
  logic signed [31:0] ground_q = 32'sd4915;
  logic signed [31:0] lift_q = 32'sd19661;
  logic signed [31:0] pitch_q = '0;
  logic signed [31:0] roll_q = '0;
  logic signed [31:0] yaw_q = '0;
  bit                 touch_q = 1'b0;
  bit                 lift_flag_q = 1'b0;
  bit                 first_q = 1'b1;

  estimate_t   pending_estimates[$];
  vector_t     directed[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;
  bit          tx_fixed = 1'b0;
  estimate_t   tx_fixed_est;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Accelerometer tilt: asin of axis over magnitude, odd-symmetric polynomial.
  function automatic longint tilt_angle(input longint axis, input longint mag);
    longint q;
    longint a;
    longint p;
    longint s;
    longint r;
    if (mag == 0) return 0;
    q = (axis * Q_ONE) / mag;
    if (q > Q_ONE) q = Q_ONE;
    if (q < -Q_ONE) q = -Q_ONE;
    a = (q < 0) ? -q : q;
    p = longint'(ASIN_C3);
    p = ((p * a) >>> 16) + longint'(ASIN_C2);
    p = ((p * a) >>> 16) + longint'(ASIN_C1);
    p = ((p * a) >>> 16) + longint'(ASIN_C0);
    s = longint'(isqrt(longint'(Q_ONE - a) << 16));
    r = longint'(HALF_PI_Q16) - ((s * p) >>> 16);
    return (q < 0) ? -r : r;
  endfunction

  // Advance the filter by one sample and return the estimate it gives.
  function automatic estimate_t filter_step(input sample_t s);
    estimate_t e;
    longint g;
    longint ax;
    longint ay;
    longint az;
    longint mag;
    longint w;
    longint pt;
    longint rt;
    longint unsigned sq;
    g = longint'(gain_q);
    if (s.pos_z < ground_q) touch_q = 1'b1;
    if (s.pos_z > lift_q) lift_flag_q = 1'b1;
    pitch_q = clamp32(longint'(pitch_q) + ((longint'(s.gyro_y) * g) >>> 16));
    roll_q = clamp32(longint'(roll_q) + ((longint'(s.gyro_x) * g) >>> 16));
    yaw_q = clamp32(longint'(yaw_q) + ((longint'(s.gyro_z) * g) >>> 16));
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    sq = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
    mag = first_q ? longint'(FIRST_MAG) : longint'(isqrt(sq));
    rt = tilt_angle(ax, mag);
    pt = tilt_angle(ay, mag);
    w = (weight_q > 17'd65536) ? Q_ONE : longint'(weight_q);
    pitch_q = clamp32(((longint'(pitch_q) * w) + pt * (Q_ONE - w)) >>> 16);
    roll_q = clamp32(((longint'(roll_q) * w) + rt * (Q_ONE - w)) >>> 16);
    first_q = 1'b0;
    e = '0;
    e.pitch_est = pitch_q;
    e.roll_est = roll_q;
    e.yaw_est = yaw_q;
    e.touched_ground = touch_q;
    e.left_ground = lift_flag_q;
    e.reward = (touch_q || lift_flag_q) ? 64'sd0 :
               longint'(s.pos_x) * longint'(s.pos_x) - longint'(s.pos_y) * longint'(s.pos_y);
    return e;
  endfunction

  // Watch all three channels at the rising edge.
  always @(posedge clk_i) begin
    estimate_t got;
    estimate_t want;
    estimate_t pred;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GYRO_GAIN:     gain_q = cfg_data_i[15:0];
          REG_BLEND_WEIGHT:  weight_q = cfg_data_i[16:0];
          REG_GROUND_HEIGHT: ground_q = cfg_data_i;
          REG_LIFT_HEIGHT:   lift_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = filter_step(sample_t'(s_axis_tdata));
        pending_estimates.push_back(tx_fixed ? tx_fixed_est : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = estimate_t'(m_axis_tdata);
        stall_left = idle_on ? $urandom_range(0, 10) : 0;
        if (pending_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $display("unexpected estimate %h", got);
        end else begin
          want = pending_estimates.pop_front();
          if (got.pitch_est !== want.pitch_est || got.roll_est !== want.roll_est ||
              got.yaw_est !== want.yaw_est || got.reward !== want.reward ||
              got.touched_ground !== want.touched_ground ||
              got.left_ground !== want.left_ground) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("estimate differs: pitch %0d/%0d roll %0d/%0d yaw %0d/%0d",
                       want.pitch_est, got.pitch_est, want.roll_est, got.roll_est,
                       want.yaw_est, got.yaw_est);
              $display("  flags %b%b/%b%b reward %0d/%0d (expected/actual)",
                       want.touched_ground, want.left_ground, got.touched_ground,
                       got.left_ground, want.reward, got.reward);
            end
          end
        end
      end
    end
  end

  // Receiver: random stalls per estimate, plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni && hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (rst_ni && stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return '0;
      3, 4: return $signed($urandom_range(0, 400000)) - 200000;
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.gyro_x = rand_word();
    s.gyro_y = rand_word();
    s.gyro_z = rand_word();
    if ($urandom_range(0, 1) == 0) begin
      // Near-level body under gravity with some shake.
      s.accel_x = $signed($urandom_range(0, 400000)) - 200000;
      s.accel_y = $signed($urandom_range(0, 400000)) - 200000;
      s.accel_z = G_Q16 + $signed($urandom_range(0, 100000)) - 50000;
    end else begin
      s.accel_x = rand_word();
      s.accel_y = rand_word();
      s.accel_z = rand_word();
    end
    s.pos_x = rand_word();
    s.pos_y = rand_word();
    s.pos_z = rand_word();
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input sample_t s, input bit fixed, input estimate_t e);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= s;
    s_axis_tvalid <= 1'b1;
    tx_fixed = fixed;
    tx_fixed_est = e;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every estimate, then let any sample still in work finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_sample(rand_sample(), 1'b0, '0);
  endtask

  function automatic void add_row(input logic signed [31:0] gx, gy, gz, ax, ay, az,
                                  input logic signed [31:0] px, py, pz);
    vector_t v;
    v.smp = '{pz, py, px, az, ay, ax, gz, gy, gx};
    v.fixed = 1'b0;
    v.est = '0;
    directed.push_back(v);
  endfunction

  initial begin
    vector_t v;
    // First sample after reset, at rest: every output is zero.
    v.smp = '{IN_BAND, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    v.fixed = 1'b1;
    v.est = '0;
    directed.push_back(v);
    add_row(S32_MAX, S32_MAX, S32_MAX, 0, 0, G_Q16, 0, 0, IN_BAND);
    add_row(S32_MIN, S32_MIN, S32_MIN, 0, 0, G_Q16, 0, 0, IN_BAND);
    // Zero magnitude gives no tilt.
    add_row(100000, -100000, 5000, 0, 0, 0, 65536, 0, IN_BAND);
    add_row(0, 0, 0, S32_MAX, S32_MIN, 0, 0, 0, IN_BAND);
    add_row(0, 0, 0, S32_MIN, S32_MAX, S32_MIN, 0, 0, IN_BAND);
    // Ratio of exactly plus and minus one.
    add_row(0, 0, 0, G_Q16, 0, 0, 0, 0, IN_BAND);
    add_row(0, 0, 0, 0, -G_Q16, 0, 0, 0, IN_BAND);
    add_row(0, 0, 0, 0, 0, G_Q16, S32_MAX, 0, IN_BAND);
    add_row(0, 0, 0, 0, 0, G_Q16, S32_MIN, S32_MIN, IN_BAND);
    add_row(0, 0, 0, 0, 0, G_Q16, 0, S32_MIN, IN_BAND);
    add_row(0, 0, 0, 0, 0, G_Q16, S32_MIN, S32_MAX, IN_BAND);
    // Heights right on the thresholds do not latch.
    add_row(1000, 2000, 3000, 1000, 2000, G_Q16, 65536, 32768, 32'sd4915);
    add_row(-1000, -2000, -3000, -1000, -2000, G_Q16, 32768, 65536, 32'sd19661);
    add_row(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, IN_BAND);
    add_row(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, IN_BAND);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_sample(directed[i].smp, directed[i].fixed, directed[i].est);
    tx_fixed = 1'b0;
    settle();

    // Thresholds at the extremes keep both flags clear, so the reward shows.
    write_reg(REG_GROUND_HEIGHT, S32_MIN);
    write_reg(REG_LIFT_HEIGHT, S32_MAX);
    run_random(200);
    settle();

    write_reg(REG_GYRO_GAIN, 32'd65535);
    write_reg(REG_BLEND_WEIGHT, 32'd0);
    idle_on = 1'b0;
    run_random(150);
    idle_on = 1'b1;
    settle();

    // Long receiver hold-off while samples keep coming.
    write_reg(REG_GYRO_GAIN, 32'd0);
    write_reg(REG_BLEND_WEIGHT, 32'd65536);
    @(posedge clk_i);
    hold_left = 400;
    @(negedge clk_i);
    run_random(100);
    settle();

    write_reg(REG_GYRO_GAIN, $urandom_range(0, 65535));
    write_reg(REG_BLEND_WEIGHT, 32'h1FFFF);
    run_random(75);
    settle();
    write_reg(REG_BLEND_WEIGHT, $urandom_range(0, 65536));
    write_reg(REG_UNUSED, $urandom);
    run_random(75);
    settle();

    // Default thresholds: the flags latch and the reward drops to zero.
    write_reg(REG_GYRO_GAIN, 32'd1872);
    write_reg(REG_BLEND_WEIGHT, 32'd65484);
    write_reg(REG_GROUND_HEIGHT, 32'd4915);
    write_reg(REG_LIFT_HEIGHT, 32'd19661);
    run_random(150);
    settle();
    write_reg(REG_GROUND_HEIGHT, S32_MAX);
    write_reg(REG_LIFT_HEIGHT, S32_MIN);
    run_random(50);
    settle();

    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
